FILE: hdl/slrg_pkg.sv
// Shared constants, command/status types and the Lehmer step function.
package slrg_pkg;

   localparam int VALUE_W           = 31;
   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int WARMUP_EXTRA      = 8;

   localparam logic [14:0]        LEHMER_A = 15'd16807;
   localparam logic [VALUE_W-1:0] MODULUS  = 31'h7FFF_FFFF;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic fill;
      logic seat;
      logic read;
      logic commit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic filled;
      logic fill_last;
      logic out_free;
   } status_type;

   // One minimal-standard step: (16807 * g) mod (2^31 - 1), by folding the high part.
   function automatic logic [VALUE_W-1:0] lehmer_next(input logic [VALUE_W-1:0] g);
      logic [45:0] prod;
      logic [31:0] fold;
      prod = 46'(g) * 46'(LEHMER_A);
      fold = {1'b0, prod[30:0]} + 32'(prod[45:31]);
      if (fold >= {1'b0, MODULUS}) begin
         fold = fold - {1'b0, MODULUS};
      end
      return fold[VALUE_W-1:0];
   endfunction

endpackage

FILE: hdl/slrg_ifs.sv
// Valid/ready channel interfaces for draw requests, results and the seed register.
interface slrg_req_if;
   logic valid;
   logic ready;
   logic reseed;

   modport source (output valid, output reseed, input ready);
   modport sink   (input valid, input reseed, output ready);
endinterface

interface slrg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [slrg_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface slrg_csr_if;
   logic                         valid;
   logic                         ready;
   logic [slrg_pkg::VALUE_W-1:0] seed;

   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface

FILE: hdl/slrg_ctrl.sv
// Sequencer for draw, reseed and table fill.
module slrg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_reseed,
   output logic                 req_ready,
   input  slrg_pkg::status_type status,
   output slrg_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FILL,
      ST_SEAT,
      ST_READ,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready = ready_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.fill   = (state_ff == ST_FILL);
      cmd.seat   = (state_ff == ST_SEAT);
      cmd.read   = (state_ff == ST_READ);
      cmd.commit = (state_ff == ST_COMMIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  ready_ff <= 1'b0;
                  // refill on request or when the table was never filled
                  if (req_reseed || !status.filled) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_LOAD: begin
               state_ff <= ST_FILL;
            end
            ST_FILL: begin
               if (status.fill_last) begin
                  state_ff <= ST_SEAT;
               end
            end
            ST_SEAT: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               // hold until the result register can take the beat
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

FILE: hdl/slrg_dp.sv
// Generator, shuffle memory, slot divider, seed and result registers.
module slrg_dp #(
   parameter int TABLE_ENTRIES = slrg_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  slrg_pkg::cmd_type            cmd,
   output slrg_pkg::status_type         status,
   input  logic                         seed_we,
   input  logic [slrg_pkg::VALUE_W-1:0] seed_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [slrg_pkg::VALUE_W-1:0] rsp_value
);

   localparam int VW     = slrg_pkg::VALUE_W;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int STEPS  = TABLE_ENTRIES + slrg_pkg::WARMUP_EXTRA;
   localparam int CNT_W  = $clog2(STEPS + 1);

   // Slot = value / SLOT_DIV, done as an exact multiply by a rounded-up reciprocal.
   localparam logic [63:0] SLOT_DIV  = 64'd1 + (64'd2147483646 / 64'(TABLE_ENTRIES));
   localparam int          DIV_BITS  = $clog2(SLOT_DIV);
   localparam int          SHIFT     = VW + DIV_BITS;
   localparam logic [63:0] RECIP     = ((64'd1 << SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
   localparam logic [32:0] RECIP_C   = RECIP[32:0];

   logic [VW-1:0]     seed_ff;
   logic [VW-1:0]     gen_ff,       gen_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic [SLOT_W-1:0] cur_slot_ff,  cur_slot_in;
   logic [VW-1:0]     rd_data_ff;
   logic              filled_ff;
   logic              out_valid_ff, out_valid_in;
   logic [VW-1:0]     out_value_ff;
   logic [VW-1:0]     shuf_mem_ff [TABLE_ENTRIES];

   logic [VW-1:0]     gen_step;
   logic [VW-1:0]     seed_fixed;
   logic [CNT_W-1:0]  cnt_dec;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [VW-1:0]     mem_wdata;
   logic [VW-1:0]     div_arg;
   logic [63:0]       div_prod;
   logic [63:0]       div_quo;
   logic [SLOT_W-1:0] div_slot;

   assign gen_step = slrg_pkg::lehmer_next(gen_ff);

   // A seed of zero or of the modulus itself starts from one.
   assign seed_fixed = (seed_ff == '0 || seed_ff == slrg_pkg::MODULUS) ? VW'(1) : seed_ff;

   assign cnt_dec = cnt_ff - CNT_W'(1);

   // Slot of the generator after a fill, else of the entry just read.
   assign div_arg  = cmd.seat ? gen_ff : rd_data_ff;
   assign div_prod = 64'(div_arg) * 64'(RECIP_C);
   assign div_quo  = div_prod >> SHIFT;
   assign div_slot = (div_quo >= 64'(TABLE_ENTRIES)) ? SLOT_W'(TABLE_ENTRIES - 1)
                                                     : div_quo[SLOT_W-1:0];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_slot_ff;
      mem_wdata = gen_ff;
      if (cmd.fill) begin
         mem_we    = (cnt_ff <= CNT_W'(TABLE_ENTRIES));
         mem_waddr = cnt_dec[SLOT_W-1:0];
         mem_wdata = gen_step;
      end else if (cmd.commit) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      gen_in = gen_ff;
      if (cmd.load) begin
         gen_in = seed_fixed;
      end else if (cmd.fill || cmd.read) begin
         gen_in = gen_step;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = CNT_W'(STEPS);
      end else if (cmd.fill) begin
         cnt_in = cnt_dec;
      end
   end

   assign cur_slot_in  = (cmd.seat || cmd.commit) ? div_slot : cur_slot_ff;
   assign out_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= VW'(1);
         filled_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (seed_we) begin
            seed_ff <= seed_data;
         end
         if (cmd.seat) begin
            filled_ff <= 1'b1;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff      <= gen_in;
      cnt_ff      <= cnt_in;
      cur_slot_ff <= cur_slot_in;
      if (cmd.commit) begin
         out_value_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shuf_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_data_ff <= shuf_mem_ff[cur_slot_ff];
      end
   end

   assign status.filled    = filled_ff;
   assign status.fill_last = (cnt_ff == CNT_W'(1));
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

endmodule

FILE: hdl/shuffled_lehmer_random_generator.sv
// Top level: minimal-standard generator with a shuffle table, one draw per request.
//
//   channel  dir  payload          beat completes on
//   req_bus  in   reseed (1 bit)   valid & ready
//   rsp_bus  out  value (31 bits)  valid & ready
//   csr_bus  in   seed (31 bits)   valid & ready (ready always high)
//
// A draw runs through accept, shuffle memory read, then store and result load.
// A reseed, and the first draw after reset, adds seed load,
// TABLE_ENTRIES + 8 generator steps and slot setup; one step per cycle.
// Reset sets the seed to 1 and marks the table unfilled.
// A result waits in the output register; the store step holds while it is not taken.
module shuffled_lehmer_random_generator #(
   parameter int TABLE_ENTRIES = slrg_pkg::TABLE_ENTRIES_DEF
) (
   input logic        clock,
   input logic        reset,
   slrg_req_if.sink   req_bus,
   slrg_rsp_if.source rsp_bus,
   slrg_csr_if.sink   csr_bus
);

   slrg_pkg::cmd_type    cmd;
   slrg_pkg::status_type status;
   logic                 seed_we;

   assign csr_bus.ready = 1'b1;
   assign seed_we       = csr_bus.valid;

   slrg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_reseed (req_bus.reseed),
      .req_ready  (req_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   slrg_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .seed_we   (seed_we),
      .seed_data (csr_bus.seed),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_value (rsp_bus.value)
   );

endmodule
